>>> rtl/sfrc8_pkg.sv
// Shared types and constants for the sextet frame receiver.
`timescale 1ns / 1ps

package sfrc8_pkg;

   // Control characters and character bias
   localparam logic [7:0] STX_CODE  = 8'h02;
   localparam logic [7:0] EOT_CODE  = 8'h04;
   localparam logic [7:0] CHAR_BIAS = 8'h20;

   // Reflected Dallas/Maxim polynomial
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Register reset values
   localparam logic [7:0] OWN_ADDRESS_RESET = 8'h21;
   localparam logic [7:0] MAX_CHARS_RESET   = 8'd64;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHARS   = 2'd1;

   typedef enum logic [0:0] {
      KIND_BYTE   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_CRC_ERROR   = 2'd1,
      STATUS_MISSING_EOT = 2'd2,
      STATUS_BAD_LENGTH  = 2'd3
   } status_type;

endpackage

>>> rtl/sextet_frame_receiver_crc8.sv
// Sextet frame receiver: deframes, decodes and CRC-8 checks a received byte stream.
`timescale 1ns / 1ps
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   req     | in        | req_valid/req_stall| req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall| rsp_kind, rsp_out_byte, rsp_status, rsp_last
//   csr     | in        | csr_write_enable   | csr_index, csr_wdata (no read-back)
//
// Flow: a word waits in the input register, then moves into the result
// bundle. A fourth payload character gives three result words; a status
// gives one; other characters give none. The bundle drains one result per
// cycle while rsp is not stalled, and takes a new word from the input
// register when empty or as its last result leaves.
// Reset (synchronous, active high) clears the frame state and both registers.
// A stalled rsp holds its word; req stalls only while the input register is
// full and the bundle is not about to empty.

module sextet_frame_receiver_crc8 (
   input  logic                                 clock,
   input  logic                                 reset,
   // received bytes
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_kind,
   output logic [7:0]                           rsp_out_byte,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [sfrc8_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                           csr_wdata
);

   // ------------------------------------------------------------------
   // CRC-8 fold of one byte, bit at a time (eight narrow steps)
   // ------------------------------------------------------------------
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ sfrc8_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [7:0]  own_address_ff, own_address_in;
   logic [7:0]  max_chars_ff,   max_chars_in;

   logic        s1_valid_ff, s1_valid_in;   // input register
   logic [7:0]  s1_byte_ff,  s1_byte_in;

   logic        in_frame_ff,    in_frame_in;
   logic [7:0]  char_index_ff,  char_index_in;
   logic [7:0]  frame_chars_ff, frame_chars_in;
   logic [17:0] sextet_hold_ff, sextet_hold_in;
   logic [7:0]  crc_ff,         crc_in;
   logic [1:0]  crc_pend_ff,    crc_pend_in;   // bytes of the bundle still to fold

   // result bundle: three bytes or one status, drained one word a cycle while rsp is not stalled
   logic                  bun_valid_ff,  bun_valid_in;
   sfrc8_pkg::kind_type   bun_kind_ff,   bun_kind_in;
   logic [23:0]           bun_word_ff,   bun_word_in;
   sfrc8_pkg::status_type bun_status_ff, bun_status_in;
   logic [1:0]            bun_idx_ff,    bun_idx_in;

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   logic pop;
   logic bun_free;
   logic s1_move;
   logic req_accept;

   assign pop        = bun_valid_ff & ~rsp_stall;
   assign bun_free   = ~bun_valid_ff |
                       (pop & ((bun_kind_ff == sfrc8_pkg::KIND_STATUS) | (bun_idx_ff == 2'd2)));
   assign s1_move    = s1_valid_ff & bun_free;
   assign req_stall  = s1_valid_ff & ~bun_free;
   assign req_accept = req_valid & ~req_stall;

   // ------------------------------------------------------------------
   // Decode of the word in the input register
   // ------------------------------------------------------------------
   logic [7:0]            sym;
   logic [7:0]            pos;
   logic                  dec_in_frame;
   logic [7:0]            dec_char_index;
   logic [7:0]            dec_frame_chars;
   logic [17:0]           dec_sextet_hold;
   logic                  dec_crc_clear;
   logic                  gen_valid;
   sfrc8_pkg::kind_type   gen_kind;
   logic [23:0]           gen_word;
   sfrc8_pkg::status_type gen_status;

   assign sym = s1_byte_ff - sfrc8_pkg::CHAR_BIAS;
   assign pos = char_index_ff - 8'd2;

   always_comb begin
      dec_in_frame    = in_frame_ff;
      dec_char_index  = char_index_ff;
      dec_frame_chars = frame_chars_ff;
      dec_sextet_hold = sextet_hold_ff;
      dec_crc_clear   = 1'b0;
      gen_valid       = 1'b0;
      gen_kind        = sfrc8_pkg::KIND_BYTE;
      gen_word        = '0;
      gen_status      = sfrc8_pkg::STATUS_OK;

      if (!in_frame_ff) begin
         // idle: wait for STX
         if (s1_byte_ff == sfrc8_pkg::STX_CODE) begin
            dec_in_frame    = 1'b1;
            dec_char_index  = 8'd0;
            dec_frame_chars = max_chars_ff;
            dec_sextet_hold = '0;
            dec_crc_clear   = 1'b1;
         end
      end else if (char_index_ff == 8'd0) begin
         // address byte; a foreign frame is dropped silently
         if (s1_byte_ff != own_address_ff) begin
            dec_in_frame = 1'b0;
         end else begin
            dec_char_index = 8'd1;
         end
      end else if (char_index_ff == 8'd1) begin
         // length character
         if ((sym > max_chars_ff) || (sym[1:0] != 2'd0)) begin
            dec_in_frame = 1'b0;
            gen_valid    = 1'b1;
            gen_kind     = sfrc8_pkg::KIND_STATUS;
            gen_status   = sfrc8_pkg::STATUS_BAD_LENGTH;
         end else begin
            dec_frame_chars = sym;
            dec_char_index  = 8'd2;
         end
      end else if (pos < frame_chars_ff) begin
         // payload character
         dec_char_index = char_index_ff + 8'd1;
         if (pos[1:0] != 2'd3) begin
            dec_sextet_hold = {sextet_hold_ff[11:0], sym[5:0]};
         end else begin
            dec_sextet_hold = '0;
            gen_valid       = 1'b1;
            gen_word        = {sextet_hold_ff, sym[5:0]};
         end
      end else begin
         // EOT position ends the frame either way
         dec_in_frame = 1'b0;
         gen_valid    = 1'b1;
         gen_kind     = sfrc8_pkg::KIND_STATUS;
         if (s1_byte_ff != sfrc8_pkg::EOT_CODE) begin
            gen_status = sfrc8_pkg::STATUS_MISSING_EOT;
         end else if (crc_ff != 8'd0) begin
            gen_status = sfrc8_pkg::STATUS_CRC_ERROR;
         end else begin
            gen_status = sfrc8_pkg::STATUS_OK;
         end
      end
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      own_address_in = own_address_ff;
      max_chars_in   = max_chars_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sfrc8_pkg::CSR_OWN_ADDRESS: own_address_in = csr_wdata;
            sfrc8_pkg::CSR_MAX_CHARS:   max_chars_in   = csr_wdata;
            default: ;
         endcase
      end

      // input register
      s1_valid_in = s1_valid_ff & ~s1_move;
      s1_byte_in  = s1_byte_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_rx_byte;
      end

      // frame state moves only when the word leaves the input register
      in_frame_in    = s1_move ? dec_in_frame    : in_frame_ff;
      char_index_in  = s1_move ? dec_char_index  : char_index_ff;
      frame_chars_in = s1_move ? dec_frame_chars : frame_chars_ff;
      sextet_hold_in = s1_move ? dec_sextet_hold : sextet_hold_ff;

      // CRC: first byte folded on load, the other two from crc_pend while the
      // bundle drains, always before its three bytes have all left
      crc_in      = crc_ff;
      crc_pend_in = crc_pend_ff;
      if (s1_move && dec_crc_clear) begin
         crc_in      = '0;
         crc_pend_in = 2'd0;
      end else if (s1_move && gen_valid && (gen_kind == sfrc8_pkg::KIND_BYTE)) begin
         crc_in      = crc8_fold(crc_ff, gen_word[23:16]);
         crc_pend_in = 2'd2;
      end else if (crc_pend_ff != 2'd0) begin
         crc_in      = crc8_fold(crc_ff, (crc_pend_ff == 2'd2) ? bun_word_ff[15:8]
                                                               : bun_word_ff[7:0]);
         crc_pend_in = crc_pend_ff - 2'd1;
      end

      // result bundle
      bun_valid_in  = bun_valid_ff;
      bun_kind_in   = bun_kind_ff;
      bun_word_in   = bun_word_ff;
      bun_status_in = bun_status_ff;
      bun_idx_in    = bun_idx_ff;
      if (bun_free) begin
         bun_valid_in = s1_move & gen_valid;
         if (s1_move && gen_valid) begin
            bun_kind_in   = gen_kind;
            bun_word_in   = gen_word;
            bun_status_in = gen_status;
            bun_idx_in    = 2'd0;
         end
      end else if (pop) begin
         bun_idx_in = bun_idx_ff + 2'd1;
      end
   end

   // ------------------------------------------------------------------
   // Clocked
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= sfrc8_pkg::OWN_ADDRESS_RESET;
         max_chars_ff   <= sfrc8_pkg::MAX_CHARS_RESET;
         s1_valid_ff    <= 1'b0;
         in_frame_ff    <= 1'b0;
         char_index_ff  <= 8'd0;
         frame_chars_ff <= sfrc8_pkg::MAX_CHARS_RESET;
         sextet_hold_ff <= '0;
         crc_ff         <= '0;
         crc_pend_ff    <= 2'd0;
         bun_valid_ff   <= 1'b0;
      end else begin
         own_address_ff <= own_address_in;
         max_chars_ff   <= max_chars_in;
         s1_valid_ff    <= s1_valid_in;
         in_frame_ff    <= in_frame_in;
         char_index_ff  <= char_index_in;
         frame_chars_ff <= frame_chars_in;
         sextet_hold_ff <= sextet_hold_in;
         crc_ff         <= crc_in;
         crc_pend_ff    <= crc_pend_in;
         bun_valid_ff   <= bun_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      bun_kind_ff   <= bun_kind_in;
      bun_word_ff   <= bun_word_in;
      bun_status_ff <= bun_status_in;
      bun_idx_ff    <= bun_idx_in;
   end

   // ------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------
   logic [7:0] sel_byte;

   always_comb begin
      case (bun_idx_ff)
         2'd0:    sel_byte = bun_word_ff[23:16];
         2'd1:    sel_byte = bun_word_ff[15:8];
         default: sel_byte = bun_word_ff[7:0];
      endcase
   end

   assign rsp_valid    = bun_valid_ff;
   assign rsp_kind     = bun_kind_ff;
   assign rsp_out_byte = (bun_kind_ff == sfrc8_pkg::KIND_STATUS) ? 8'd0 : sel_byte;
   assign rsp_status   = (bun_kind_ff == sfrc8_pkg::KIND_STATUS) ? bun_status_ff
                                                                 : sfrc8_pkg::STATUS_OK;
   assign rsp_last     = (bun_kind_ff == sfrc8_pkg::KIND_STATUS) | (bun_idx_ff == 2'd2);

endmodule

>>> rtl/sfrc8_checker.sv
// Port-level checks for the sextet frame receiver, bound to the top level.
`timescale 1ns / 1ps

module sfrc8_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   // status words are always single and last
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == sfrc8_pkg::KIND_STATUS) |-> (rsp_last && rsp_out_byte == 8'd0))
      else $error("status word not last or carries a byte");

   // decoded bytes carry no status
   a_byte_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == sfrc8_pkg::KIND_BYTE) |-> (rsp_status == sfrc8_pkg::STATUS_OK))
      else $error("byte word carries a status");

   // a byte that is not last is followed by another byte of the same group
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_kind == sfrc8_pkg::KIND_BYTE && !rsp_last)
      |=> (rsp_valid && rsp_kind == sfrc8_pkg::KIND_BYTE))
      else $error("byte group broken");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte)
                                    && $stable(rsp_status) && $stable(rsp_last)))
      else $error("stalled rsp word changed");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind sextet_frame_receiver_crc8 sfrc8_checker u_sfrc8_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_kind     (rsp_kind),
   .rsp_out_byte (rsp_out_byte),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);
